// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the same cycle as its condition.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its condition.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/cslx_pkg.sv =====
package cslx_pkg;

    // Result kinds
    localparam logic [1:0] KIND_ECHO   = 2'd0;
    localparam logic [1:0] KIND_STRING = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // Source bytes with a meaning to the scanner
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Result queue sizing
    localparam int RES_MAX    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } res_t;

    // Simple escape letters: returns {hit, decoded byte}
    function automatic logic [8:0] esc_decode(input logic [7:0] b);
        logic [8:0] r;
        case (b)
            8'h62:     r = {1'b1, 8'h08};   // b
            8'h74:     r = {1'b1, 8'h09};   // t
            8'h72:     r = {1'b1, 8'h0D};   // r
            8'h6E:     r = {1'b1, 8'h0A};   // n
            8'h66:     r = {1'b1, 8'h0C};   // f
            CH_BSLASH: r = {1'b1, CH_BSLASH};
            CH_DQUOTE: r = {1'b1, CH_DQUOTE};
            default:   r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/cslx_in_if.sv =====
interface cslx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink   (input valid, input source_byte, output ready);
endinterface

// ===== hw/rtl/cslx_out_if.sv =====
interface cslx_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic       last;

    modport source (output valid, output kind, output value, output last, input ready);
    modport sink   (input valid, input kind, input value, input last, output ready);
endinterface

// ===== hw/rtl/c_string_literal_extractor.sv =====
// Channel   Dir  Payload                       Request
// source    in   source_byte[7:0]              one byte of C source text
// result    out  kind[1:0] value[7:0] last     one echoed byte, string byte or end marker
//
// One source byte is taken per cycle while the queue has room. The byte is held in
// the input register, and its zero to three results are written together into a
// four-entry result queue that drains one result per cycle while result is ready;
// the byte in the input register waits while the queue holds more than one entry.
// rst_n clears the scanner state, the input register and the queue.
// A stall on result fills the queue and then holds source ready low.
module c_string_literal_extractor
    import cslx_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    cslx_in_if.sink   source,
    cslx_out_if.source result
);

    typedef enum logic [2:0] {
        M_CODE        = 3'd0,
        M_COMMENT     = 3'd1,
        M_CHAR        = 3'd2,
        M_DIR_CODE    = 3'd3,
        M_DIR_COMMENT = 3'd4,
        M_STRING      = 3'd5,
        M_ESC         = 3'd6,
        M_OCTAL       = 3'd7
    } mode_t;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // Scanner state
    mode_t      mode_reg, mode_next;
    logic       line_start_reg, line_start_next;
    logic       slash_reg, slash_next;
    logic       star_reg, star_next;
    logic [5:0] oct_val_reg, oct_val_next;
    logic       oct_two_reg, oct_two_next;   // two octal digits pending

    // Result queue
    res_t             fifo_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    // Results of the byte in the input register
    logic [1:0] res_kind  [RES_MAX];
    logic [7:0] res_value [RES_MAX];
    logic [1:0] res_cnt;

    logic       consume;
    logic       pop;
    logic       accept;
    logic       nl;
    logic       is_oct;
    logic       str_path;
    logic [8:0] esc;
    logic [8:0] oct_sum;

    // Process the held byte only when the queue has room for a full burst,
    // so source ready never depends combinationally on result ready.
    assign consume = in_valid_reg && (count_reg <= CNT_W'(FIFO_DEPTH - RES_MAX));
    assign pop     = result.valid && result.ready;
    assign accept  = source.valid && source.ready;

    assign source.ready = !in_valid_reg || consume;

    assign result.valid = (count_reg != '0);
    assign result.kind  = fifo_reg[rd_ptr_reg].kind;
    assign result.value = fifo_reg[rd_ptr_reg].value;
    assign result.last  = fifo_reg[rd_ptr_reg].last;

    assign nl      = (in_byte_reg == CH_NL);
    assign is_oct  = (in_byte_reg[7:3] == 5'b00110);
    assign esc     = esc_decode(in_byte_reg);
    assign oct_sum = {oct_val_reg, in_byte_reg[2:0]};

    always_comb
    begin
        mode_next       = mode_reg;
        line_start_next = line_start_reg;
        slash_next      = slash_reg;
        star_next       = star_reg;
        oct_val_next    = oct_val_reg;
        oct_two_next    = oct_two_reg;
        str_path        = 1'b0;
        res_cnt         = 2'd0;
        for (int i = 0; i < RES_MAX; i++)
        begin
            res_kind[i]  = KIND_ECHO;
            res_value[i] = 8'd0;
        end

        case (mode_reg)
            M_STRING:
            begin
                str_path = 1'b1;
            end
            M_ESC:
            begin
                if (nl)
                begin
                    // backslash-newline: continue the string silently
                    mode_next = M_STRING;
                end
                else if (esc[8])
                begin
                    res_kind[res_cnt]  = KIND_STRING;
                    res_value[res_cnt] = esc[7:0];
                    res_cnt            = res_cnt + 2'd1;
                    mode_next          = M_STRING;
                end
                else if (is_oct)
                begin
                    oct_val_next = {3'd0, in_byte_reg[2:0]};
                    oct_two_next = 1'b0;
                    mode_next    = M_OCTAL;
                end
                else
                begin
                    // unknown escape: keep the backslash and the byte
                    res_kind[res_cnt]  = KIND_STRING;
                    res_value[res_cnt] = CH_BSLASH;
                    res_cnt            = res_cnt + 2'd1;
                    res_kind[res_cnt]  = KIND_STRING;
                    res_value[res_cnt] = in_byte_reg;
                    res_cnt            = res_cnt + 2'd1;
                    mode_next          = M_STRING;
                end
            end
            M_OCTAL:
            begin
                if (is_oct)
                begin
                    if (oct_two_reg)
                    begin
                        res_kind[res_cnt]  = KIND_STRING;
                        res_value[res_cnt] = oct_sum[7:0];
                        res_cnt            = res_cnt + 2'd1;
                        oct_val_next       = 6'd0;
                        oct_two_next       = 1'b0;
                        mode_next          = M_STRING;
                    end
                    else
                    begin
                        oct_val_next = oct_sum[5:0];
                        oct_two_next = 1'b1;
                    end
                end
                else
                begin
                    // short escape ends: emit it, then handle the byte as content
                    res_kind[res_cnt]  = KIND_STRING;
                    res_value[res_cnt] = {2'd0, oct_val_reg};
                    res_cnt            = res_cnt + 2'd1;
                    oct_val_next       = 6'd0;
                    oct_two_next       = 1'b0;
                    mode_next          = M_STRING;
                    str_path           = 1'b1;
                end
            end
            M_CHAR:
            begin
                res_kind[res_cnt]  = KIND_ECHO;
                res_value[res_cnt] = in_byte_reg;
                res_cnt            = res_cnt + 2'd1;
                mode_next          = M_CODE;
                line_start_next    = nl;
            end
            M_DIR_CODE, M_DIR_COMMENT:
            begin
                res_kind[res_cnt]  = KIND_ECHO;
                res_value[res_cnt] = in_byte_reg;
                res_cnt            = res_cnt + 2'd1;
                if (nl)
                begin
                    mode_next       = (mode_reg == M_DIR_CODE) ? M_CODE : M_COMMENT;
                    line_start_next = 1'b1;
                end
            end
            M_COMMENT:
            begin
                res_kind[res_cnt]  = KIND_ECHO;
                res_value[res_cnt] = in_byte_reg;
                res_cnt            = res_cnt + 2'd1;
                if (line_start_reg && in_byte_reg == CH_HASH)
                begin
                    mode_next  = M_DIR_COMMENT;
                    star_next  = 1'b0;
                    slash_next = 1'b0;
                end
                else if (in_byte_reg == CH_SLASH && star_reg)
                begin
                    mode_next  = M_CODE;
                    star_next  = 1'b0;
                    slash_next = 1'b0;
                end
                else
                begin
                    star_next = (in_byte_reg == CH_STAR);
                end
                line_start_next = nl;
            end
            default:
            begin
                // plain code
                if (line_start_reg && in_byte_reg == CH_HASH)
                begin
                    res_kind[res_cnt]  = KIND_ECHO;
                    res_value[res_cnt] = in_byte_reg;
                    res_cnt            = res_cnt + 2'd1;
                    mode_next          = M_DIR_CODE;
                    slash_next         = 1'b0;
                    star_next          = 1'b0;
                end
                else if (in_byte_reg == CH_DQUOTE)
                begin
                    // opening quote is dropped
                    mode_next  = M_STRING;
                    slash_next = 1'b0;
                end
                else if (in_byte_reg == CH_SQUOTE)
                begin
                    res_kind[res_cnt]  = KIND_ECHO;
                    res_value[res_cnt] = in_byte_reg;
                    res_cnt            = res_cnt + 2'd1;
                    mode_next          = M_CHAR;
                    slash_next         = 1'b0;
                end
                else if (in_byte_reg == CH_STAR && slash_reg)
                begin
                    res_kind[res_cnt]  = KIND_ECHO;
                    res_value[res_cnt] = in_byte_reg;
                    res_cnt            = res_cnt + 2'd1;
                    mode_next          = M_COMMENT;
                    slash_next         = 1'b0;
                    star_next          = 1'b0;
                end
                else
                begin
                    res_kind[res_cnt]  = KIND_ECHO;
                    res_value[res_cnt] = in_byte_reg;
                    res_cnt            = res_cnt + 2'd1;
                    slash_next         = (in_byte_reg == CH_SLASH);
                end
                line_start_next = nl;
            end
        endcase

        // String content, shared by the string mode and a finished octal escape
        if (str_path)
        begin
            if (in_byte_reg == CH_DQUOTE)
            begin
                res_kind[res_cnt]  = KIND_END;
                res_value[res_cnt] = 8'd0;
                res_cnt            = res_cnt + 2'd1;
                mode_next          = M_CODE;
            end
            else if (nl)
            begin
                res_kind[res_cnt]  = KIND_STRING;
                res_value[res_cnt] = CH_NL;
                res_cnt            = res_cnt + 2'd1;
                res_kind[res_cnt]  = KIND_END;
                res_value[res_cnt] = 8'd0;
                res_cnt            = res_cnt + 2'd1;
                mode_next          = M_CODE;
                line_start_next    = 1'b1;
            end
            else if (in_byte_reg == CH_BSLASH)
            begin
                mode_next = M_ESC;
            end
            else
            begin
                res_kind[res_cnt]  = KIND_STRING;
                res_value[res_cnt] = in_byte_reg;
                res_cnt            = res_cnt + 2'd1;
            end
        end
    end

    // Input register: load on accept, drop once processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (consume)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_byte_reg <= source.source_byte;
        end
    end

    // Scanner state: advance once per processed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_CODE;
            line_start_reg <= 1'b1;
            slash_reg      <= 1'b0;
            star_reg       <= 1'b0;
            oct_val_reg    <= 6'd0;
            oct_two_reg    <= 1'b0;
        end
        else if (consume)
        begin
            mode_reg       <= mode_next;
            line_start_reg <= line_start_next;
            slash_reg      <= slash_next;
            star_reg       <= star_next;
            oct_val_reg    <= oct_val_next;
            oct_two_reg    <= oct_two_next;
        end
    end

    // Result queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (consume)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(res_cnt);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (consume ? CNT_W'(res_cnt) : CNT_W'(0))
                                   - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // Result queue storage: write the whole burst at once, last flag on the final one
    always_ff @(posedge clk)
    begin
        if (consume)
        begin
            for (int i = 0; i < RES_MAX; i++)
            begin
                if (2'(i) < res_cnt)
                begin
                    fifo_reg[wr_ptr_reg + PTR_W'(i)] <= '{kind:  res_kind[i],
                                                          value: res_value[i],
                                                          last:  (2'(i) == res_cnt - 2'd1)};
                end
            end
        end
    end

endmodule

// ===== hw/rtl/cslx_checker.sv =====
`include "assert_macros.svh"

module cslx_checker
    import cslx_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] res_kind,
    input logic [7:0] res_value,
    input logic       res_last
);

    // Hold a stalled result
    `ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_kind) && $stable(res_value) && $stable(res_last), "stalled result changed")

    // End marker closes the burst of its byte and carries zero
    `ASSERT_IMPL(a_end_last, clk, rst_n, res_valid && res_kind == KIND_END, res_last && res_value == 8'd0, "bad string end marker")

    // Echoed bytes come one per source byte
    `ASSERT_IMPL(a_echo_single, clk, rst_n, res_valid && res_kind == KIND_ECHO, res_last, "echo not last")

    // A burst drains without gaps and holds only string bytes and end markers
    `ASSERT_NEXT(a_burst_contig, clk, rst_n, res_valid && res_ready && !res_last, res_valid && res_kind != KIND_ECHO, "burst broken")

endmodule

bind c_string_literal_extractor cslx_checker u_cslx_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_kind  (result.kind),
    .res_value (result.value),
    .res_last  (result.last)
);
